// ===== rtl/core/glyph_text_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// Glyph text rasterizer assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_RASTERIZER_DEFINES_SVH
`define GLYPH_TEXT_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset.
`define GTR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("glyph_text_rasterizer assertion failed");

// Condition in one cycle implies a condition in the following cycle.
`define GTR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  `GTR_ASSERT(lbl, clk, rst_n, (pre) |=> (post))

`else

`define GTR_ASSERT(lbl, clk, rst_n, prop)
`define GTR_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/core/gtr_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph text rasterizer package
// Font table, widths, state codes and shared helpers.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int GLYPH_ROWS   = 7;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_CELLS  = GLYPH_ROWS * GLYPH_COLS;
  localparam int CELL_ADVANCE = 6;

  localparam int CHAR_W  = 8;
  localparam int COORD_W = 16;
  localparam int SCALE_W = 6;
  localparam int COLOR_W = 32;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;
  // Scaled offsets stay below 2^9; accumulators get two headroom bits.
  localparam int STEP_W  = 9;
  localparam int ACC_W   = COORD_W + 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);
  localparam logic [COLOR_W-1:0] COLOR_RESET = '1;

  typedef enum logic {
    CFG_PIXEL_SCALE = 1'b0,
    CFG_DRAW_COLOR  = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } scan_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } square_t;

  // Clamp a widened coordinate to the 16-bit signed range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-COORD_W:0] top;
    top = v[ACC_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[COORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // Glyph bitmap in scan order: row 0 in the top five bits, leftmost column first.
  function automatic logic [GLYPH_CELLS-1:0] glyph_bits(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] c;
    logic [GLYPH_CELLS-1:0] g;
    c = code;
    if (c inside {[8'h61:8'h7a]}) begin
      c = c - 8'h20;
    end
    case (c)
      8'h30: g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e}; // 0
      8'h31: g = {5'h04, 5'h0c, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1f}; // 1
      8'h32: g = {5'h0e, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1f}; // 2
      8'h33: g = {5'h1e, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1e}; // 3
      8'h34: g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02}; // 4
      8'h35: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e}; // 5
      8'h36: g = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e}; // 6
      8'h37: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
      8'h38: g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e}; // 8
      8'h39: g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e}; // 9
      8'h41: g = {5'h04, 5'h0a, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11}; // A
      8'h45: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f}; // E
      8'h47: g = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0e}; // G
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11}; // H
      8'h49: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f}; // I
      8'h4f: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e}; // O
      8'h50: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10}; // P
      8'h52: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11}; // R
      8'h53: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e}; // S
      8'h54: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
      8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a}; // W
      8'h3a: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // colon
      8'h2e: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06}; // dot
      8'h2d: g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00}; // minus
      default: g = '0; // space and every code outside the font
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/gtr_alu.sv =====
// ----------------------------------------------------------------------------
// Glyph text rasterizer shared adder
// Adds an unsigned step to a widened coordinate and saturates the sum.
// ----------------------------------------------------------------------------
module gtr_alu (
  input  logic signed [gtr_pkg::ACC_W-1:0]   a_i,
  input  logic        [gtr_pkg::STEP_W-1:0]  b_i,
  output logic signed [gtr_pkg::ACC_W-1:0]   sum_o,
  output logic signed [gtr_pkg::COORD_W-1:0] sat_o
);
  import gtr_pkg::*;

  assign sum_o = a_i + $signed(ACC_W'(b_i));
  assign sat_o = sat_coord(sum_o);

endmodule

// ===== rtl/core/gtr_scan.sv =====
// ----------------------------------------------------------------------------
// Glyph text rasterizer scan sequencer
// Walks the 35 glyph cells and steps the cursor through the shared adder.
// ----------------------------------------------------------------------------
`include "glyph_text_rasterizer_defines.svh"

module gtr_scan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic [gtr_pkg::CHAR_W-1:0]         character_i,
  input  logic                               string_start_i,
  input  logic signed [gtr_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [gtr_pkg::COORD_W-1:0] origin_y_i,
  input  logic [gtr_pkg::SCALE_W-1:0]        pixel_scale_i,
  input  logic                               emit_ok_i,
  output logic                               idle_o,
  output logic                               emit_valid_o,
  output gtr_pkg::square_t                   emit_o
);
  import gtr_pkg::*;

  scan_state_t               state_r, state_nxt;
  logic [GLYPH_CELLS-1:0]    bits_r, bits_nxt;
  logic [ROW_W-1:0]          glyph_row_r, glyph_row_nxt;
  logic [COL_W-1:0]          glyph_col_r, glyph_col_nxt;
  logic signed [COORD_W-1:0] cursor_x_r, cursor_x_nxt;
  logic signed [COORD_W-1:0] line_y_r, line_y_nxt;
  logic signed [ACC_W-1:0]   x_acc_r, x_acc_nxt;
  logic signed [ACC_W-1:0]   y_acc_r, y_acc_nxt;

  logic signed [ACC_W-1:0]   alu_a;
  logic [STEP_W-1:0]         alu_b;
  logic signed [ACC_W-1:0]   alu_sum;
  logic signed [COORD_W-1:0] alu_sat;
  logic [STEP_W-1:0]         scale_step;
  logic [STEP_W-1:0]         advance_step;
  logic [GLYPH_CELLS-1:0]    glyph;
  logic [GLYPH_CELLS-1:0]    bits_shifted;
  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] base_y;
  logic                      row_end;
  logic                      stall;

  assign scale_step   = STEP_W'(pixel_scale_i);
  assign advance_step = STEP_W'(pixel_scale_i) * STEP_W'(CELL_ADVANCE);
  assign glyph        = (pixel_scale_i == '0) ? '0 : glyph_bits(character_i);
  assign bits_shifted = bits_r << 1;
  assign row_end      = (glyph_col_r == COL_W'(GLYPH_COLS - 1));
  assign base_x       = string_start_i ? origin_x_i : cursor_x_r;
  assign base_y       = string_start_i ? origin_y_i : line_y_r;

  // One adder serves the column step, the row step and the cursor advance.
  always_comb begin
    if (state_r == ST_DONE) begin
      alu_a = ACC_W'(cursor_x_r);
      alu_b = advance_step;
    end else if (row_end) begin
      alu_a = y_acc_r;
      alu_b = scale_step;
    end else begin
      alu_a = x_acc_r;
      alu_b = scale_step;
    end
  end

  gtr_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .sat_o (alu_sat)
  );

  assign idle_o       = (state_r == ST_IDLE);
  assign emit_valid_o = (state_r == ST_SCAN) && bits_r[GLYPH_CELLS-1];
  assign emit_o.x     = sat_coord(x_acc_r);
  assign emit_o.y     = sat_coord(y_acc_r);
  assign emit_o.last  = ~|bits_r[GLYPH_CELLS-2:0];
  assign stall        = emit_valid_o && !emit_ok_i;

  always_comb begin
    state_nxt     = state_r;
    bits_nxt      = bits_r;
    glyph_row_nxt = glyph_row_r;
    glyph_col_nxt = glyph_col_r;
    cursor_x_nxt  = cursor_x_r;
    line_y_nxt    = line_y_r;
    x_acc_nxt     = x_acc_r;
    y_acc_nxt     = y_acc_r;
    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          cursor_x_nxt  = base_x;
          line_y_nxt    = base_y;
          x_acc_nxt     = ACC_W'(base_x);
          y_acc_nxt     = ACC_W'(base_y);
          bits_nxt      = glyph;
          glyph_row_nxt = '0;
          glyph_col_nxt = '0;
          state_nxt     = (glyph == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          bits_nxt = bits_shifted;
          if (bits_shifted == '0) begin
            // No set pixel left in the glyph: skip the rest of the cell.
            glyph_row_nxt = '0;
            glyph_col_nxt = '0;
            state_nxt     = ST_DONE;
          end else if (row_end) begin
            glyph_col_nxt = '0;
            glyph_row_nxt = glyph_row_r + ROW_W'(1);
            x_acc_nxt     = ACC_W'(cursor_x_r);
            y_acc_nxt     = alu_sum;
          end else begin
            glyph_col_nxt = glyph_col_r + COL_W'(1);
            x_acc_nxt     = alu_sum;
          end
        end
      end
      ST_DONE: begin
        cursor_x_nxt = alu_sat;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      glyph_row_r <= '0;
      glyph_col_r <= '0;
      cursor_x_r  <= '0;
      line_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      glyph_row_r <= glyph_row_nxt;
      glyph_col_r <= glyph_col_nxt;
      cursor_x_r  <= cursor_x_nxt;
      line_y_r    <= line_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r  <= bits_nxt;
    x_acc_r <= x_acc_nxt;
    y_acc_r <= y_acc_nxt;
  end

  `GTR_ASSERT(a_scan_pos_in_cell, clk, rst_n, (state_r != ST_SCAN) || (glyph_col_r < COL_W'(GLYPH_COLS) && glyph_row_r < ROW_W'(GLYPH_ROWS)))
  `GTR_ASSERT(a_idle_pos_zero, clk, rst_n, (state_r != ST_IDLE) || (glyph_col_r == '0 && glyph_row_r == '0))
  `GTR_ASSERT_NEXT(a_done_to_idle, clk, rst_n, state_r == ST_DONE, state_r == ST_IDLE)
  `GTR_ASSERT_NEXT(a_last_ends_scan, clk, rst_n, emit_valid_o && emit_ok_i && emit_o.last, state_r == ST_DONE)

endmodule

// ===== rtl/core/glyph_text_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Glyph text rasterizer
// Turns text characters into filled squares from a built-in 5x7 font.
// ----------------------------------------------------------------------------
// Each accepted character beat is looked up in a 5x7 font (digits, the
// letters A E G H I O P R S T W in either case, colon, dot, minus and space;
// anything else draws blank) and produces one square beat per set pixel,
// scanned row by row from the top and left to right, with last_square set on
// the final one. After acceptance the scan steps through the glyph cells up
// to and including the last set pixel (at most 35 cells), then advances the
// cursor, and in_ready stays low until that is done; a blank glyph or a zero
// scale draws nothing and goes straight to the cursor advance. The scan
// holds while a square is ready but the output register is still held. A
// single shared adder steps the column offset, the row offset and finally
// the cursor, one addition per cycle unless held. Coordinates
// saturate to the 16-bit signed range. The configuration port is always
// ready; write pixel_scale and draw_color only while the block is idle.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gtr_pkg::CHAR_W-1:0]         in_character,
  input  logic                               in_string_start,
  input  logic signed [gtr_pkg::COORD_W-1:0] in_origin_x,
  input  logic signed [gtr_pkg::COORD_W-1:0] in_origin_y,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gtr_pkg::COORD_W-1:0] out_square_x,
  output logic signed [gtr_pkg::COORD_W-1:0] out_square_y,
  output logic [gtr_pkg::SCALE_W-1:0]        out_square_size,
  output logic [gtr_pkg::COLOR_W-1:0]        out_square_color,
  output logic                               out_last_square,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  gtr_pkg::cfg_index_t                cfg_index,
  input  logic [gtr_pkg::COLOR_W-1:0]        cfg_data
);
  import gtr_pkg::*;

  logic [SCALE_W-1:0]        pixel_scale_r, pixel_scale_nxt;
  logic [COLOR_W-1:0]        draw_color_r, draw_color_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] square_x_r, square_x_nxt;
  logic signed [COORD_W-1:0] square_y_r, square_y_nxt;
  logic [SCALE_W-1:0]        square_size_r, square_size_nxt;
  logic [COLOR_W-1:0]        square_color_r, square_color_nxt;
  logic                      last_square_r, last_square_nxt;

  logic    scan_idle;
  logic    emit_valid;
  logic    emit_ok;
  logic    emit_take;
  logic    cfg_write;
  square_t emit;

  // Registers are always writable; the data bus carries the scale in its low bits.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    pixel_scale_nxt = pixel_scale_r;
    draw_color_nxt  = draw_color_r;
    if (cfg_write) begin
      case (cfg_index)
        CFG_PIXEL_SCALE: pixel_scale_nxt = cfg_data[SCALE_W-1:0];
        CFG_DRAW_COLOR:  draw_color_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = scan_idle;

  gtr_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .start_i        (in_valid && in_ready),
    .character_i    (in_character),
    .string_start_i (in_string_start),
    .origin_x_i     (in_origin_x),
    .origin_y_i     (in_origin_y),
    .pixel_scale_i  (pixel_scale_r),
    .emit_ok_i      (emit_ok),
    .idle_o         (scan_idle),
    .emit_valid_o   (emit_valid),
    .emit_o         (emit)
  );

  // The output register takes a new square whenever it is empty or being
  // drained in the same cycle, so the scan never waits on a free register.
  assign emit_ok   = !out_valid_r || out_ready;
  assign emit_take = emit_valid && emit_ok;

  always_comb begin
    out_valid_nxt    = out_valid_r;
    square_x_nxt     = square_x_r;
    square_y_nxt     = square_y_r;
    square_size_nxt  = square_size_r;
    square_color_nxt = square_color_r;
    last_square_nxt  = last_square_r;
    if (emit_take) begin
      out_valid_nxt    = 1'b1;
      square_x_nxt     = emit.x;
      square_y_nxt     = emit.y;
      square_size_nxt  = pixel_scale_r;
      square_color_nxt = draw_color_r;
      last_square_nxt  = emit.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_scale_r <= SCALE_RESET;
      draw_color_r  <= COLOR_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      pixel_scale_r <= pixel_scale_nxt;
      draw_color_r  <= draw_color_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    square_x_r     <= square_x_nxt;
    square_y_r     <= square_y_nxt;
    square_size_r  <= square_size_nxt;
    square_color_r <= square_color_nxt;
    last_square_r  <= last_square_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_square_x     = square_x_r;
  assign out_square_y     = square_y_r;
  assign out_square_size  = square_size_r;
  assign out_square_color = square_color_r;
  assign out_last_square  = last_square_r;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text rasterizer testbench
// Drives text characters through the rasterizer and checks each square it
// draws against a cycle-free model of the 5x7 font, the cursor and the
// coordinate clamping, under random idling on both sides and a long output
// stall.
// ----------------------------------------------------------------------------
module testbench;
  import gtr_pkg::*;

  // A long receiver stall, so that the block fills up and holds off input.
  localparam int LONG_HOLD = 400;
  // Allows the slowest character to finish after acceptance, plus stalls.
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 40;
  // Every character that has a glyph in the font, upper case only.
  localparam string FONT_CHARSET = "0123456789AEGHIOPRSTW:.- ";

  // Row 0 is the top row; bit 4 of a row is the leftmost column.
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_map_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SCALE_W-1:0]        size;
    logic [COLOR_W-1:0]        color;
    logic                      last;
  } square_beat_t;

  // Keeps its own copy of the registers and the text cursor, turns every
  // accepted character into the squares it must draw, and checks the
  // squares that come out in order.
  class square_scoreboard;
    logic [SCALE_W-1:0]        scale;
    logic [COLOR_W-1:0]        color;
    logic signed [COORD_W-1:0] cursor_x;
    logic signed [COORD_W-1:0] line_y;
    square_beat_t              expected_squares[$];
    int                        errors;
    int                        characters;
    int                        squares;

    function new();
      scale      = SCALE_RESET;
      color      = COLOR_RESET;
      cursor_x   = '0;
      line_y     = '0;
      errors     = 0;
      characters = 0;
      squares    = 0;
    endfunction

    static function logic signed [COORD_W-1:0] clamp(int v);
      if (v > 32767) begin
        return 16'sh7fff;
      end else if (v < -32768) begin
        return 16'sh8000;
      end
      return 16'(v);
    endfunction

    static function glyph_map_t font_rows(logic [CHAR_W-1:0] code);
      logic [CHAR_W-1:0] c;
      c = code;
      if (c >= "a" && c <= "z") begin
        c = c - 8'h20;
      end
      case (c)
        "0": return {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
        "1": return {5'h04, 5'h0c, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1f};
        "2": return {5'h0e, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1f};
        "3": return {5'h1e, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1e};
        "4": return {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
        "5": return {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
        "6": return {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
        "7": return {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
        "8": return {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
        "9": return {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
        "A": return {5'h04, 5'h0a, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11};
        "E": return {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
        "G": return {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0e};
        "H": return {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
        "I": return {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
        "O": return {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
        "P": return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
        "R": return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
        "S": return {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
        "T": return {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
        "W": return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
        ":": return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
        ".": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
        "-": return {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
        default: return '0;
      endcase
    endfunction

    function void apply_register(cfg_index_t idx, logic [COLOR_W-1:0] data);
      case (idx)
        CFG_PIXEL_SCALE: scale = data[SCALE_W-1:0];
        CFG_DRAW_COLOR:  color = data;
        default: ;
      endcase
    endfunction

    function void note_character(logic [CHAR_W-1:0] code, logic start,
                                 logic signed [COORD_W-1:0] org_x,
                                 logic signed [COORD_W-1:0] org_y);
      glyph_map_t   rows;
      int           total;
      int           emitted;
      int           r;
      int           c;
      square_beat_t sq;
      rows = font_rows(code);
      characters++;
      if (start) begin
        cursor_x = org_x;
        line_y   = org_y;
      end
      total   = (scale == 0) ? 0 : $countones(rows);
      emitted = 0;
      if (total != 0) begin
        for (r = 0; r < GLYPH_ROWS; r++) begin
          for (c = 0; c < GLYPH_COLS; c++) begin
            if (rows[r][GLYPH_COLS-1-c]) begin
              emitted++;
              sq.x     = clamp(int'(cursor_x) + c * int'(scale));
              sq.y     = clamp(int'(line_y) + r * int'(scale));
              sq.size  = scale;
              sq.color = color;
              sq.last  = (emitted == total);
              expected_squares.push_back(sq);
            end
          end
        end
      end
      cursor_x = clamp(int'(cursor_x) + CELL_ADVANCE * int'(scale));
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_square(square_beat_t got);
      square_beat_t want;
      squares++;
      if (expected_squares.size() == 0) begin
        errors++;
        $display("%0t: square at (%0d,%0d) arrived with none expected, expected none, actual 1",
                 $time, got.x, got.y);
        return;
      end
      want = expected_squares.pop_front();
      if (got.x != want.x)         report("square_x", want.x, got.x);
      if (got.y != want.y)         report("square_y", want.y, got.y);
      if (got.size != want.size)   report("square_size", want.size, got.size);
      if (got.color != want.color) report("square_color", want.color, got.color);
      if (got.last != want.last)   report("last_square", want.last, got.last);
    endfunction

    function int pending();
      return expected_squares.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CHAR_W-1:0]         in_character = '0;
  logic                      in_string_start = 1'b0;
  logic signed [COORD_W-1:0] in_origin_x = '0;
  logic signed [COORD_W-1:0] in_origin_y = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_square_x;
  logic signed [COORD_W-1:0] out_square_y;
  logic [SCALE_W-1:0]        out_square_size;
  logic [COLOR_W-1:0]        out_square_color;
  logic                      out_last_square;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  cfg_index_t                cfg_index = CFG_PIXEL_SCALE;
  logic [COLOR_W-1:0]        cfg_data = '0;

  square_scoreboard board;
  // Set by the stimulus when the long output stall should happen; the
  // receiver clears it once the stall has started.
  bit hold_request = 1'b0;
  int burst_left = 1;
  int settings_used = 0;

  glyph_text_rasterizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .in_string_start  (in_string_start),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_square_x     (out_square_x),
    .out_square_y     (out_square_y),
    .out_square_size  (out_square_size),
    .out_square_color (out_square_color),
    .out_last_square  (out_last_square),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every process samples right after the rising edge, before any of this
  // edge's nonblocking updates land, so both sides see the values that were
  // stable during the cycle that just ended.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_square({out_square_x, out_square_y, out_square_size,
                          out_square_color, out_last_square});
    end
  end

  // Receiver: runs through segments of always ready, coin-flip ready, mostly
  // stalled and toggling, with one long hold when the stimulus asks for it.
  initial begin : receiver
    int mode;
    int len;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(8, 60);
        repeat (len) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Writes both registers back to back. The valid stays high across the two
  // beats and drops once the second one has gone in.
  task automatic set_config(logic [SCALE_W-1:0] scale, logic [COLOR_W-1:0] color);
    cfg_index_t         idx;
    logic [COLOR_W-1:0] data;
    for (int i = 0; i < 2; i++) begin
      if (i == 0) begin
        idx  = CFG_PIXEL_SCALE;
        // The upper bits are ignored by the register, so fill them with noise.
        data = {26'($urandom), scale};
      end else begin
        idx  = CFG_DRAW_COLOR;
        data = color;
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk); while (!cfg_ready);
      board.apply_register(idx, data);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Offers one character and waits for it to be taken. The sender works in
  // bursts: the valid stays high from one beat to the next until a burst
  // runs out, then drops for a random gap with noise on the payload.
  task automatic offer_character(logic [CHAR_W-1:0] code, logic start,
                                 logic signed [COORD_W-1:0] org_x,
                                 logic signed [COORD_W-1:0] org_y);
    int gap;
    in_valid        <= 1'b1;
    in_character    <= code;
    in_string_start <= start;
    in_origin_x     <= org_x;
    in_origin_y     <= org_y;
    do @(posedge clk); while (!in_ready);
    board.note_character(code, start, org_x, org_y);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      in_valid        <= 1'b0;
      in_character    <= 8'($urandom);
      in_string_start <= 1'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Brings the block back to idle: stop offering, let every expected square
  // arrive, then allow for a character that draws nothing to finish.
  task automatic finish_phase();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] random_character();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 9) < 7) begin
      c = FONT_CHARSET[$urandom_range(0, FONT_CHARSET.len() - 1)];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
        c = c + 8'h20;
      end
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Origins cluster near both ends of the range so the clamping is hit,
  // with plenty of full-range and moderate values too.
  function automatic logic signed [COORD_W-1:0] random_origin();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = 32767 - int'($urandom_range(0, 500));
      2: v = -32768 + int'($urandom_range(0, 300));
      default: v = int'($urandom_range(0, 4000)) - 2000;
    endcase
    return 16'(v);
  endfunction

  // Mostly well-formed strings: a start with a fresh origin, then characters
  // that follow on. A few strings never get a start and a few restart in the
  // middle.
  task automatic send_strings(int count);
    int                        sent;
    int                        len;
    int                        i;
    logic                      start;
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 12);
      for (i = 0; i < len && sent < count; i++) begin
        if (i == 0) begin
          start = ($urandom_range(0, 9) != 0);
        end else begin
          start = ($urandom_range(0, 19) == 0);
        end
        // When there is no start the origin is ignored, so it carries noise.
        org_x = start ? random_origin() : 16'($urandom);
        org_y = start ? random_origin() : 16'($urandom);
        offer_character(random_character(), start, org_x, org_y);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    string             text;
    logic [SCALE_W-1:0] scale;
    logic [COLOR_W-1:0] color;
    board = new();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings. The first character carries no
    // start, so it must draw from the reset cursor at the origin. Then a
    // folded lower-case letter, a code outside the font, and the punctuation.
    offer_character("8", 1'b0, 16'sh1234, -16'sd77);
    offer_character("a", 1'b0, '0, '0);
    offer_character("W", 1'b0, '0, '0);
    offer_character(8'hff, 1'b0, '0, '0);
    offer_character(" ", 1'b0, '0, '0);
    offer_character(":", 1'b0, '0, '0);
    offer_character(".", 1'b0, '0, '0);
    offer_character("-", 1'b0, '0, '0);
    finish_phase();

    // Largest scale near the top of the range: squares and the cursor clamp.
    // Then a string at the very bottom corner of the range.
    set_config(6'd63, 32'h0000_0000);
    offer_character("H", 1'b1, 16'sd32700, 16'sd32700);
    offer_character("0", 1'b0, '0, '0);
    offer_character("E", 1'b1, 16'sh8000, 16'sh8000);
    finish_phase();

    // A zero scale draws nothing and leaves the cursor where it is.
    set_config(6'd0, 32'hffff_ffff);
    offer_character("T", 1'b1, 16'sd10, 16'sd10);
    offer_character("8", 1'b0, '0, '0);
    finish_phase();

    // The rest of the digits and letters at a small scale.
    set_config(6'd2, 32'ha5a5_5a5a);
    text = "1g2P3r4S5O6I79";
    for (int i = 0; i < text.len(); i++) begin
      offer_character(text[i], (i == 0), -16'sd100, 16'sd50);
    end
    finish_phase();

    // Random part: one register setting per phase, extremes included.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: scale = 6'd1;
        1: scale = 6'd63;
        2: scale = 6'd0;
        3: scale = 6'd2;
        4: scale = 6'($urandom_range(3, 62));
        5: scale = 6'd4;
        6: scale = 6'd1;
        default: scale = 6'($urandom_range(1, 63));
      endcase
      case (p)
        0: color = '0;
        1: color = '1;
        default: color = $urandom;
      endcase
      set_config(scale, color);
      // Part way through, hold the output off for a long stretch while the
      // sender keeps offering, so the block backs up into its input.
      if (p == 3) begin
        hold_request = 1'b1;
      end
      send_strings(PHASE_ITEMS);
      finish_phase();
    end

    $display("Checked %0d squares from %0d characters over %0d register settings.",
             board.squares, board.characters, settings_used + 1);
    $display("Covered every glyph, folded case, unknown codes, zero and full scale, clamping.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Far beyond the slowest legal run; reaching it means the block hung.
  initial begin : watchdog
    #5_000_000;
    $display("%0t: timeout with %0d squares still expected", $time, board.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
